// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is held.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/bfa_pkg.sv =====
package bfa_pkg;

  localparam int FRAME_COUNT_DEF = 8192;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int FRAME_W  = 13;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 14;

  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REF    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNREF   = 2'd2;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_REF,
    OP_REL,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

endpackage

// ===== sv/bfa_ram.sv =====
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/bfa_front.sv =====
module bfa_front #(
  parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfa_pkg::KIND_W-1:0]   in_kind,
  input  logic [bfa_pkg::FRAME_W-1:0]  in_frame_index,
  output logic                         q_valid,
  output bfa_pkg::cmd_t                q_cmd,
  input  logic                         q_pop
);

  bfa_pkg::cmd_t q_mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  bfa_pkg::cmd_t cls;
  logic          in_range;
  logic          push;

  assign in_range = 17'(in_frame_index) < 17'(FRAME_COUNT);

  always_comb begin
    cls.frame = in_frame_index;
    cls.op    = bfa_pkg::OP_NOP;
    unique case (in_kind)
      bfa_pkg::KIND_FIND: cls.op = bfa_pkg::OP_FIND;
      bfa_pkg::KIND_REF:  cls.op = in_range ? bfa_pkg::OP_REF : bfa_pkg::OP_NOP;
      bfa_pkg::KIND_REL:  cls.op = in_range ? bfa_pkg::OP_REL : bfa_pkg::OP_NOP;
      default:            cls.op = bfa_pkg::OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== sv/bfa_back.sv =====
module bfa_back #(
  parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
  parameter int COUNT_WIDTH = bfa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bfa_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfa_pkg::FRAME_W-1:0]   out_found_frame,
  output logic [bfa_pkg::STATUS_W-1:0]  out_status,
  output logic [bfa_pkg::FREE_W-1:0]    out_free_count
);

  localparam int ROW_COUNT = (FRAME_COUNT + 31) / 32;
  localparam int GRP_COUNT = (ROW_COUNT + 31) / 32;
  localparam int RA_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int GRP_W     = (GRP_COUNT > 1) ? $clog2(GRP_COUNT) : 1;
  localparam int FA_W      = $clog2(FRAME_COUNT);
  localparam int FCNT_W    = $clog2(FRAME_COUNT + 1);
  localparam int LAST_BITS = FRAME_COUNT - (ROW_COUNT - 1) * 32;
  localparam logic [32:0] LAST_ONES = (33'd1 << LAST_BITS) - 33'd1;
  localparam logic [31:0] LAST_PAD  = ~LAST_ONES[31:0];
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_FROW,
    S_FBIT,
    S_EX
  } state_t;

  function automatic logic [4:0] first_zero(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!v[i]) p = 5'(i);
    end
    return p;
  endfunction

  state_t                    state_r;
  bfa_pkg::cmd_t             cmd_r;
  logic [GRP_W-1:0]          grp_r;
  logic [RA_W-1:0]           row_r;
  logic [ROW_COUNT-1:0]      row_full_r;
  logic [ROW_COUNT-1:0]      row_valid_r;
  logic [FCNT_W-1:0]         free_r;
  logic                      out_valid_r;
  logic [bfa_pkg::FRAME_W-1:0]  out_frame_r;
  logic [bfa_pkg::STATUS_W-1:0] out_status_r;

  logic [GRP_COUNT*32-1:0]   rf_pad;
  logic [GRP_COUNT-1:0]      grp_full;
  logic [GRP_W-1:0]          grp_sel;
  logic [31:0]               grp_rows;
  logic [RA_W-1:0]           found_row;
  logic [RA_W-1:0]           cmd_row;
  logic [4:0]                cmd_bit;
  logic                      is_upd;
  logic                      can_out;

  logic                      bm_we;
  logic                      bm_re;
  logic [RA_W-1:0]           bm_addr;
  logic [31:0]               bm_rdata;
  logic [31:0]               bm_cur;
  logic [31:0]               row_pad;
  logic [31:0]               row_nxt;
  logic [4:0]                bit_pos;

  logic                      cnt_we;
  logic                      cnt_re;
  logic [COUNT_WIDTH-1:0]    cnt_rdata;
  logic [COUNT_WIDTH-1:0]    c_cur;
  logic [COUNT_WIDTH-1:0]    c_nxt;
  logic [FCNT_W-1:0]         free_nxt;
  logic [bfa_pkg::STATUS_W-1:0] ex_status;
  logic                      bit_nxt;

  // padded rows beyond the last real row count as full
  always_comb begin
    rf_pad = '1;
    rf_pad[ROW_COUNT-1:0] = row_full_r;
  end

  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_full[g] = &rf_pad[g*32 +: 32];
    end
    grp_sel = '0;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (!grp_full[g]) grp_sel = GRP_W'(g);
    end
  end

  assign grp_rows  = rf_pad[{grp_r, 5'd0} +: 32];
  assign found_row = RA_W'({grp_r, first_zero(grp_rows)});
  assign cmd_row   = RA_W'(cmd_r.frame >> 5);
  assign cmd_bit   = cmd_r.frame[4:0];
  assign is_upd    = (cmd_r.op == bfa_pkg::OP_REF) || (cmd_r.op == bfa_pkg::OP_REL);
  assign can_out   = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  assign bm_addr = (state_r == S_FROW) ? found_row : cmd_row;
  assign bm_re   = (state_r == S_FROW) || ((state_r == S_DEC) && is_upd);
  assign cnt_re  = (state_r == S_DEC) && is_upd;
  assign bm_we   = (state_r == S_EX) && can_out;
  assign cnt_we  = bm_we;

  // a row never written reads as all free
  assign bm_cur  = row_valid_r[row_r] ? bm_rdata : 32'd0;
  assign row_pad = (row_r == RA_W'(ROW_COUNT - 1)) ? LAST_PAD : 32'd0;
  assign bit_pos = first_zero(bm_cur | row_pad);

  // count is only meaningful while the frame's used bit is set
  assign c_cur = bm_cur[cmd_bit] ? cnt_rdata : '0;

  always_comb begin
    c_nxt     = c_cur;
    free_nxt  = free_r;
    ex_status = bfa_pkg::ST_OK;
    bit_nxt   = bm_cur[cmd_bit];
    if (cmd_r.op == bfa_pkg::OP_REF) begin
      bit_nxt = 1'b1;
      if (c_cur == '0) free_nxt = free_r - 1'b1;
      if (c_cur != CNT_MAX) c_nxt = c_cur + 1'b1;
    end else if (c_cur == '0) begin
      ex_status = bfa_pkg::ST_UNREF;
    end else begin
      c_nxt = c_cur - 1'b1;
      if (c_nxt == '0) begin
        bit_nxt  = 1'b0;
        free_nxt = free_r + 1'b1;
      end
    end
    row_nxt          = bm_cur;
    row_nxt[cmd_bit] = bit_nxt;
  end

  bfa_ram #(.WIDTH(32), .DEPTH(ROW_COUNT)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .re    (bm_re),
    .addr  (bm_addr),
    .wdata (row_nxt),
    .rdata (bm_rdata)
  );

  bfa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(FRAME_COUNT)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .re    (cnt_re),
    .addr  (FA_W'(cmd_r.frame)),
    .wdata (c_nxt),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_full_r  <= '0;
      row_valid_r <= '0;
      free_r      <= FCNT_W'(FRAME_COUNT);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_cmd;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          unique case (cmd_r.op)
            bfa_pkg::OP_FIND: begin
              if (free_r != '0) begin
                grp_r   <= grp_sel;
                state_r <= S_FROW;
              end else if (can_out) begin
                out_valid_r  <= 1'b1;
                out_frame_r  <= '0;
                out_status_r <= bfa_pkg::ST_NO_FREE;
                state_r      <= S_IDLE;
              end
            end
            bfa_pkg::OP_REF, bfa_pkg::OP_REL: begin
              row_r   <= cmd_row;
              state_r <= S_EX;
            end
            default: begin
              if (can_out) begin
                out_valid_r  <= 1'b1;
                out_frame_r  <= cmd_r.frame;
                out_status_r <= bfa_pkg::ST_OK;
                state_r      <= S_IDLE;
              end
            end
          endcase
        end
        S_FROW: begin
          row_r   <= found_row;
          state_r <= S_FBIT;
        end
        S_FBIT: begin
          if (can_out) begin
            out_valid_r  <= 1'b1;
            out_frame_r  <= bfa_pkg::FRAME_W'({row_r, bit_pos});
            out_status_r <= bfa_pkg::ST_OK;
            state_r      <= S_IDLE;
          end
        end
        S_EX: begin
          if (can_out) begin
            row_valid_r[row_r] <= 1'b1;
            row_full_r[row_r]  <= &(row_nxt | row_pad);
            free_r             <= free_nxt;
            out_valid_r        <= 1'b1;
            out_frame_r        <= cmd_r.frame;
            out_status_r       <= ex_status;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found_frame = out_frame_r;
  assign out_status      = out_status_r;
  assign out_free_count  = bfa_pkg::FREE_W'(free_r);

endmodule

// ===== sv/bitmap_frame_allocator_unit.sv =====
// Page-frame allocator: one item in, one result out. Items are classified and
// queued (two entries) at the input, then executed one at a time by a
// sequencer around a bitmap RAM (one 32-bit row per 32 frames) and a
// reference count RAM. An ignored request or a find with no free frame is
// answered from the decode state; a reference or release does one RAM read
// and one write; a successful find does a group pick from per-row full bits,
// a row read and a bit pick. The sequencer pops the queue only while idle,
// so it takes no new item until the last result is registered, and holds
// while a finished result waits on the output. No clearing pass: per-row
// valid bits make the store read as free right after reset.
module bitmap_frame_allocator_unit #(
  parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
  parameter int COUNT_WIDTH = bfa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfa_pkg::KIND_W-1:0]    in_kind,
  input  logic [bfa_pkg::FRAME_W-1:0]   in_frame_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfa_pkg::FRAME_W-1:0]   out_found_frame,
  output logic [bfa_pkg::STATUS_W-1:0]  out_status,
  output logic [bfa_pkg::FREE_W-1:0]    out_free_count
);

  logic          q_valid;
  logic          q_pop;
  bfa_pkg::cmd_t q_cmd;

  bfa_front #(.FRAME_COUNT(FRAME_COUNT)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_frame_index (in_frame_index),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  bfa_back #(.FRAME_COUNT(FRAME_COUNT), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_frame (out_found_frame),
    .out_status      (out_status),
    .out_free_count  (out_free_count)
  );

endmodule

// ===== sv/bfa_checker.sv =====
`include "assert_macros.svh"

module bfa_checker #(
  parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bfa_pkg::FRAME_W-1:0]   out_found_frame,
  input logic [bfa_pkg::STATUS_W-1:0]  out_status,
  input logic [bfa_pkg::FREE_W-1:0]    out_free_count
);

  logic out_stall;
  logic no_free;

  assign out_stall = out_valid && !out_ready;
  assign no_free   = out_valid && (out_status == bfa_pkg::ST_NO_FREE);

  // stalled result holds
  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(out_found_frame) && $stable(out_status))
  `ASSERT_CLK(a_status_code, out_valid |-> out_status <= bfa_pkg::ST_UNREF)
  `ASSERT_CLK(a_no_free_zero, no_free |-> out_found_frame == '0)
  `ASSERT_CLK(a_free_bound, 17'(out_free_count) <= 17'(FRAME_COUNT))
  // full allocator reports a zero free count
  `ASSERT_CLK(a_no_free_cnt, no_free |-> out_free_count == '0)

endmodule

bind bitmap_frame_allocator_unit bfa_checker #(.FRAME_COUNT(FRAME_COUNT)) u_bfa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_found_frame (out_found_frame),
  .out_status      (out_status),
  .out_free_count  (out_free_count)
);
